// ----- src/amfg_pkg.sv -----
// ----------------------------------------------------------------------------
// amfg_pkg: shared types and helpers for the actuator mode sequencer
// Channel state record, tick payloads, mode codes and gain step functions.
// ----------------------------------------------------------------------------
package amfg_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int DW = 16;
  localparam int LIMW = 15;
  localparam int NGAINS = 4;

  localparam logic [15:0] RAMP_RATE_RST = 16'd10;
  localparam logic [14:0] GAIN_MAX_RST = 15'd32767;

  localparam logic CFG_RAMP_RATE = 1'b0;
  localparam logic CFG_GAIN_MAX = 1'b1;

  localparam logic [1:0] REQ_OFF = 2'd0;
  localparam logic [1:0] REQ_OPEN = 2'd1;
  localparam logic [1:0] REQ_LOOP = 2'd2;

  typedef enum logic [2:0] {
    ST_OFF       = 3'd0,
    ST_PWM       = 3'd1,
    ST_RAMP_UP   = 3'd2,
    ST_PID       = 3'd3,
    ST_RAMP_DOWN = 3'd4,
    ST_ABORT     = 3'd5
  } state_t;

  typedef logic signed [DW-1:0] gain_t;

  typedef struct packed {
    state_t                  state;
    logic [15:0]             counter;
    gain_t [NGAINS-1:0]      gains;
    logic signed [DW-1:0]    dac;
  } chan_t;

  typedef struct packed {
    logic [1:0]              channel;
    logic [1:0]              mode_req;
    logic signed [DW-1:0]    demand;
    gain_t [NGAINS-1:0]      target;
    logic                    limit_pos_hit;
    logic                    limit_neg_hit;
    logic                    stop_pos_enable;
    logic                    stop_neg_enable;
    logic                    watchdog_expired;
  } item_t;

  typedef struct packed {
    logic signed [DW-1:0]    dac_value;
    logic                    amp_enable;
    logic [2:0]              mode_state;
    gain_t [NGAINS-1:0]      live;
  } result_t;

  typedef struct packed {
    logic [15:0]             ramp_rate;
    logic [LIMW-1:0]         gain_max;
  } cfg_t;

  function automatic gain_t step_up(gain_t g, gain_t t, logic [LIMW-1:0] lim);
    logic signed [DW:0] v;
    logic signed [DW:0] l;
    v = {g[DW-1], g};
    l = {2'b00, lim};
    if (g < t) begin
      v = v + 17'sd1;
    end else begin
      v = v - 17'sd1;
    end
    if (v > l) begin
      v = l;
    end
    if (v < -l) begin
      v = -l;
    end
    return v[DW-1:0];
  endfunction

  function automatic gain_t step_down(gain_t g);
    gain_t v;
    v = g;
    if (g > 16'sd0) begin
      v = g - 16'sd1;
    end else if (g < 16'sd0) begin
      v = g + 16'sd1;
    end
    return v;
  endfunction

endpackage

// ----- src/amfg_bank.sv -----
// ----------------------------------------------------------------------------
// amfg_bank: per-channel state storage
// One state record per channel, combinational read, single write port.
// ----------------------------------------------------------------------------
module amfg_bank #(
  parameter int NUM_CHANNELS = amfg_pkg::NUM_CHANNELS_DEF,
  parameter int IDXW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IDXW-1:0]     rd_idx,
  output amfg_pkg::chan_t     rd_data,
  input  logic                wr_en,
  input  logic [IDXW-1:0]     wr_idx,
  input  amfg_pkg::chan_t     wr_data
);
  import amfg_pkg::*;

  chan_t bank_r [NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        bank_r[i] <= '{state: ST_OFF, default: '0};
      end
    end else if (wr_en) begin
      bank_r[wr_idx] <= wr_data;
    end
  end

  assign rd_data = bank_r[rd_idx];

endmodule

// ----- src/amfg_tick.sv -----
// ----------------------------------------------------------------------------
// amfg_tick: one control tick for one channel
// Mode state machine, ramp counter, gain stepping and DAC stop logic.
// ----------------------------------------------------------------------------
module amfg_tick (
  input  amfg_pkg::item_t     item,
  input  amfg_pkg::chan_t     cur,
  input  amfg_pkg::cfg_t      cfg,
  output amfg_pkg::chan_t     nxt,
  output amfg_pkg::result_t   res
);
  import amfg_pkg::*;

  logic signed [DW-1:0] drive;
  logic [15:0]          cnt_inc;
  logic                 step;
  gain_t [NGAINS-1:0]   up_g;
  gain_t [NGAINS-1:0]   dn_g;
  logic                 up_moved;
  logic                 dn_moved;
  logic                 amp;
  state_t               st;

  always_comb begin
    drive = item.demand;
    if ((item.stop_pos_enable && item.limit_pos_hit && item.demand > 16'sd0) ||
        (item.stop_neg_enable && item.limit_neg_hit && item.demand < 16'sd0)) begin
      drive = '0;
    end
  end

  assign cnt_inc = cur.counter + 16'd1;
  assign step    = (cnt_inc >= cfg.ramp_rate);

  always_comb begin
    up_moved = 1'b0;
    dn_moved = 1'b0;
    for (int i = 0; i < NGAINS; i++) begin
      up_g[i] = cur.gains[i];
      dn_g[i] = cur.gains[i];
      if (cur.gains[i] != item.target[i]) begin
        up_moved = 1'b1;
        up_g[i]  = step_up(cur.gains[i], item.target[i], cfg.gain_max);
      end
      if (cur.gains[i] != 16'sd0) begin
        dn_moved = 1'b1;
        dn_g[i]  = step_down(cur.gains[i]);
      end
    end
  end

  always_comb begin
    nxt = cur;
    amp = 1'b0;
    st  = item.watchdog_expired ? ST_ABORT : cur.state;
    unique case (st)
      ST_OFF: begin
        nxt.dac     = '0;
        nxt.gains   = '0;
        nxt.counter = '0;
        nxt.state   = ST_OFF;
        if (item.mode_req == REQ_OPEN) begin
          nxt.state = ST_PWM;
        end else if (item.mode_req == REQ_LOOP) begin
          nxt.state = ST_RAMP_UP;
        end
      end
      ST_PWM: begin
        amp       = 1'b1;
        nxt.dac   = drive;
        nxt.state = (item.mode_req == REQ_OPEN) ? ST_PWM : ST_OFF;
      end
      ST_RAMP_UP, ST_PID: begin
        amp = 1'b1;
        if (item.mode_req != REQ_LOOP) begin
          nxt.state = (st == ST_RAMP_UP) ? ST_OFF : ST_RAMP_DOWN;
        end else begin
          nxt.state   = st;
          nxt.dac     = drive;
          nxt.counter = step ? 16'd0 : cnt_inc;
          if (step) begin
            nxt.gains = up_g;
            if (!up_moved && st == ST_RAMP_UP) begin
              nxt.state = ST_PID;
            end
          end
        end
      end
      ST_RAMP_DOWN: begin
        nxt.dac     = '0;
        nxt.state   = ST_RAMP_DOWN;
        nxt.counter = step ? 16'd0 : cnt_inc;
        if (step) begin
          nxt.gains = dn_g;
          if (!dn_moved) begin
            nxt.state = ST_OFF;
          end
        end
      end
      default: begin
        nxt.state = ST_ABORT;
        nxt.dac   = '0;
      end
    endcase
  end

  always_comb begin
    res.dac_value  = nxt.dac;
    res.amp_enable = amp;
    res.mode_state = nxt.state;
    res.live       = nxt.gains;
  end

endmodule

// ----- src/actuator_mode_fsm_gain_ramp.sv -----
// ----------------------------------------------------------------------------
// actuator_mode_fsm_gain_ramp: per-channel actuator mode sequencer
// Runs the off/pwm/ramp/pid/abort machine and the gain ramp per channel.
// ----------------------------------------------------------------------------
// channel  direction  handshake         beat
// in_      input      in_valid/in_stall one control tick
// out_     output     out_valid/out_stall one tick result
// cfg_     input      cfg_we            one register write
//
// A tick enters the input register, and when the output advances its channel
// record is read, updated and written back while the result is registered, so
// one beat per cycle is sustained while out_stall is low. Reset clears all
// channel records and loads the register defaults. A stalled output holds the
// input register, and in_stall rises only while both registers are full.
// ----------------------------------------------------------------------------
module actuator_mode_fsm_gain_ramp #(
  parameter int NUM_CHANNELS = amfg_pkg::NUM_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_channel,
  input  logic [1:0]         in_mode_req,
  input  logic signed [15:0] in_demand,
  input  logic signed [15:0] in_target_kp,
  input  logic signed [15:0] in_target_ki,
  input  logic signed [15:0] in_target_kd,
  input  logic signed [15:0] in_target_kff,
  input  logic               in_limit_pos_hit,
  input  logic               in_limit_neg_hit,
  input  logic               in_stop_pos_enable,
  input  logic               in_stop_neg_enable,
  input  logic               in_watchdog_expired,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_dac_value,
  output logic               out_amp_enable,
  output logic [2:0]         out_mode_state,
  output logic signed [15:0] out_live_kp,
  output logic signed [15:0] out_live_ki,
  output logic signed [15:0] out_live_kd,
  output logic signed [15:0] out_live_kff,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import amfg_pkg::*;

  localparam int IDXW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CW = (IDXW > 2) ? IDXW : 2;

  cfg_t    cfg_r;
  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;

  logic            advance;
  logic            in_acc;
  logic            commit;
  logic [CW-1:0]   chan_ext;
  logic            in_range;
  logic [IDXW-1:0] idx;
  chan_t           cur;
  chan_t           nxt;
  result_t         res;
  item_t           in_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ramp_rate <= RAMP_RATE_RST;
      cfg_r.gain_max  <= GAIN_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RAMP_RATE: cfg_r.ramp_rate <= cfg_data;
        CFG_GAIN_MAX:  cfg_r.gain_max  <= cfg_data[LIMW-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_acc   = in_valid && !in_stall;
  assign commit   = s1_valid_r && advance;

  always_comb begin
    in_item.channel          = in_channel;
    in_item.mode_req         = in_mode_req;
    in_item.demand           = in_demand;
    in_item.target           = {in_target_kff, in_target_kd, in_target_ki, in_target_kp};
    in_item.limit_pos_hit    = in_limit_pos_hit;
    in_item.limit_neg_hit    = in_limit_neg_hit;
    in_item.stop_pos_enable  = in_stop_pos_enable;
    in_item.stop_neg_enable  = in_stop_neg_enable;
    in_item.watchdog_expired = in_watchdog_expired;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance || !s1_valid_r) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
  end

  assign chan_ext = CW'(s1_item_r.channel);
  assign in_range = (32'(s1_item_r.channel) < NUM_CHANNELS);
  assign idx      = chan_ext[IDXW-1:0];

  amfg_bank #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .IDXW         (IDXW)
  ) u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (idx),
    .rd_data (cur),
    .wr_en   (commit && in_range),
    .wr_idx  (idx),
    .wr_data (nxt)
  );

  amfg_tick u_tick (
    .item (s1_item_r),
    .cur  (cur),
    .cfg  (cfg_r),
    .nxt  (nxt),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_res_r <= in_range ? res : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dac_value  = out_res_r.dac_value;
  assign out_amp_enable = out_res_r.amp_enable;
  assign out_mode_state = out_res_r.mode_state;
  assign out_live_kp    = out_res_r.live[0];
  assign out_live_ki    = out_res_r.live[1];
  assign out_live_kd    = out_res_r.live[2];
  assign out_live_kff   = out_res_r.live[3];

endmodule
